// ===== hw/rtl/lsbsd_pkg.sv =====
// Shared constants, codes and register map of the LSB stego stream decoder.
package lsbsd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned APB_DW  = 32;
    localparam int unsigned APB_AW  = 3;
    localparam int unsigned MAGIC_W = 16;
    localparam int unsigned SKIP_W  = 8;
    localparam int unsigned FIELD_W = 32;
    localparam int unsigned BITC_W  = 5;
    localparam int unsigned PHASE_W = 3;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_EXT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    // Register indexes (word address bit paddr[2]).
    localparam logic REG_MAGIC_WORD  = 1'b0;
    localparam logic REG_HEADER_SKIP = 1'b1;

    localparam logic [MAGIC_W-1:0] MAGIC_WORD_RST  = 16'd8746;
    localparam logic [SKIP_W-1:0]  HEADER_SKIP_RST = 8'd54;

    // Field lengths in bits, reduced modulo 32 to match the 5-bit bit counter.
    localparam logic [BITC_W-1:0] MAGIC_BITS  = 5'd16;
    localparam logic [BITC_W-1:0] LENGTH_BITS = 5'd0;
    localparam logic [BITC_W-1:0] BYTE_BITS   = 5'd8;

endpackage

// ===== hw/rtl/lsbsd_in_if.sv =====
// Valid/ready channel carrying raw carrier bytes into the decoder.
interface lsbsd_in_if;
    logic                           valid;
    logic                           ready;
    logic [lsbsd_pkg::BYTE_W-1:0]   stego_byte;
    logic                           start_req;

    modport source (output valid, output stego_byte, output start_req, input ready);
    modport sink   (input valid, input stego_byte, input start_req, output ready);
endinterface

// ===== hw/rtl/lsbsd_out_if.sv =====
// Valid/ready channel carrying decoded result words out of the decoder.
interface lsbsd_out_if;
    logic                           valid;
    logic                           ready;
    logic [lsbsd_pkg::BYTE_W-1:0]   out_byte;
    logic [lsbsd_pkg::KIND_W-1:0]   kind;
    logic                           last;

    modport source (output valid, output out_byte, output kind, output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

// ===== hw/rtl/lsb_stego_stream_decoder_unit.sv =====
// Top level of the LSB steganography stream decoder.
//
// Usage: raw bytes of a carrier image file enter on stego_ch, one word per
// handshake; start_req marks the first byte of a new file and restarts the
// decode. After header_skip bytes, bit 0 of each byte is collected LSB first
// into a 16-bit magic, a 32-bit extension length, the extension bytes, a
// 32-bit data length and the data bytes. Each extension and data byte leaves
// on result_ch as one word with kind and a last flag; a magic mismatch gives
// one error word and the decoder halts until the next start_req.
// A byte passes through the input register and then the result register.
// Throughput is one byte per cycle while result_ch.ready stays high, set by
// the state update between the input register and the result register.
// When the receiver stalls, the result register holds its word; the input
// register still drains into it once it empties, and stego_ch.ready drops
// only while both registers are full and result_ch.ready is low. Reset clears
// both registers' valid flags, loads magic_word = 8746 and header_skip = 54,
// and puts the decoder in the header skip phase, as if a file had just
// started. Registers must be written over the APB port only while the decoder
// is idle (user's duty, unenforced): magic_word at 0, header_skip at 4.
module lsb_stego_stream_decoder_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lsbsd_pkg::APB_AW-1:0]       paddr,
    input  logic [lsbsd_pkg::APB_DW-1:0]       pwdata,
    output logic [lsbsd_pkg::APB_DW-1:0]       prdata,
    output logic                               pready,
    lsbsd_in_if.sink                           stego_ch,
    lsbsd_out_if.source                        result_ch
);

    // Decode phases.
    localparam logic [lsbsd_pkg::PHASE_W-1:0] PH_SKIP    = 3'd0;
    localparam logic [lsbsd_pkg::PHASE_W-1:0] PH_MAGIC   = 3'd1;
    localparam logic [lsbsd_pkg::PHASE_W-1:0] PH_EXTLEN  = 3'd2;
    localparam logic [lsbsd_pkg::PHASE_W-1:0] PH_EXT     = 3'd3;
    localparam logic [lsbsd_pkg::PHASE_W-1:0] PH_DATALEN = 3'd4;
    localparam logic [lsbsd_pkg::PHASE_W-1:0] PH_DATA    = 3'd5;
    localparam logic [lsbsd_pkg::PHASE_W-1:0] PH_HALT    = 3'd6;

    // Configuration registers.
    logic [lsbsd_pkg::MAGIC_W-1:0] magic_word_reg;
    logic [lsbsd_pkg::SKIP_W-1:0]  header_skip_reg;
    logic                          cfg_write;

    // Input register: only bit 0 of the byte and the start flag matter.
    logic s1_valid_reg;
    logic s1_bit_reg;
    logic s1_start_reg;
    logic advance;

    // Decode state.
    logic [lsbsd_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [lsbsd_pkg::SKIP_W-1:0]  skip_cnt_reg, skip_cnt_next;
    logic [lsbsd_pkg::BITC_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [lsbsd_pkg::FIELD_W-1:0] acc_reg, acc_next;
    logic [lsbsd_pkg::FIELD_W-1:0] remain_reg, remain_next;

    // Result register.
    logic                          out_valid_reg, out_valid_next;
    logic [lsbsd_pkg::BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic [lsbsd_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic                          last_reg, last_next;
    logic                          emit;

    //------------------------------------------------------------------
    // APB register file. pready is tied high; the word address is paddr[2].
    //------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_word_reg  <= lsbsd_pkg::MAGIC_WORD_RST;
            header_skip_reg <= lsbsd_pkg::HEADER_SKIP_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                lsbsd_pkg::REG_MAGIC_WORD:  magic_word_reg  <= pwdata[lsbsd_pkg::MAGIC_W-1:0];
                lsbsd_pkg::REG_HEADER_SKIP: header_skip_reg <= pwdata[lsbsd_pkg::SKIP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (paddr[2])
            lsbsd_pkg::REG_MAGIC_WORD:  prdata = 32'(magic_word_reg);
            lsbsd_pkg::REG_HEADER_SKIP: prdata = 32'(header_skip_reg);
            default:                    prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // Handshake. The input register moves on whenever the result register
    // is empty or its word is being taken this cycle.
    //------------------------------------------------------------------
    assign advance        = !out_valid_reg || result_ch.ready;
    assign stego_ch.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (stego_ch.ready)
        begin
            s1_valid_reg <= stego_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stego_ch.ready && stego_ch.valid)
        begin
            s1_bit_reg   <= stego_ch.stego_byte[0];
            s1_start_reg <= stego_ch.start_req;
        end
    end

    //------------------------------------------------------------------
    // Decode step for the word in the input register.
    //------------------------------------------------------------------
    always_comb
    begin
        logic [lsbsd_pkg::PHASE_W-1:0] ph;
        logic [lsbsd_pkg::SKIP_W-1:0]  skc;
        logic [lsbsd_pkg::BITC_W-1:0]  bc;
        logic [lsbsd_pkg::FIELD_W-1:0] acc;
        logic [lsbsd_pkg::FIELD_W-1:0] rem;
        logic [lsbsd_pkg::BITC_W-1:0]  width;
        logic                          gather;

        ph     = phase_reg;
        skc    = skip_cnt_reg;
        bc     = bit_cnt_reg;
        acc    = acc_reg;
        rem    = remain_reg;
        gather = 1'b0;
        width  = lsbsd_pkg::BYTE_BITS;

        emit          = 1'b0;
        out_byte_next = '0;
        kind_next     = lsbsd_pkg::KIND_EXT;
        last_next     = 1'b0;

        // A start flag restarts the file with this byte as its first byte.
        if (s1_start_reg)
        begin
            ph  = PH_SKIP;
            skc = '0;
            bc  = '0;
            acc = '0;
            rem = '0;
        end

        if (ph == PH_SKIP)
        begin
            if (skc < header_skip_reg)
            begin
                skc = skc + lsbsd_pkg::SKIP_W'(1);
            end
            else
            begin
                ph     = PH_MAGIC;
                bc     = '0;
                acc    = '0;
                gather = 1'b1;
            end
        end
        else if (ph != PH_HALT)
        begin
            gather = 1'b1;
        end

        if (gather)
        begin
            case (ph)
                PH_MAGIC:              width = lsbsd_pkg::MAGIC_BITS;
                PH_EXTLEN, PH_DATALEN: width = lsbsd_pkg::LENGTH_BITS;
                default:               width = lsbsd_pkg::BYTE_BITS;
            endcase

            acc = acc | (lsbsd_pkg::FIELD_W'(s1_bit_reg) << bc);
            bc  = bc + lsbsd_pkg::BITC_W'(1);

            // The field is complete; a 32-bit field ends when the counter wraps.
            if (bc == width)
            begin
                bc = '0;
                case (ph)
                    PH_MAGIC:
                    begin
                        if (acc[lsbsd_pkg::MAGIC_W-1:0] != magic_word_reg)
                        begin
                            ph        = PH_HALT;
                            emit      = 1'b1;
                            kind_next = lsbsd_pkg::KIND_ERROR;
                        end
                        else
                        begin
                            ph = PH_EXTLEN;
                        end
                    end
                    PH_EXTLEN:
                    begin
                        rem = acc;
                        ph  = (acc == '0) ? PH_DATALEN : PH_EXT;
                    end
                    PH_EXT:
                    begin
                        emit          = 1'b1;
                        out_byte_next = acc[lsbsd_pkg::BYTE_W-1:0];
                        kind_next     = lsbsd_pkg::KIND_EXT;
                        last_next     = (rem == lsbsd_pkg::FIELD_W'(1));
                        rem           = rem - lsbsd_pkg::FIELD_W'(1);
                        if (rem == '0)
                        begin
                            ph = PH_DATALEN;
                        end
                    end
                    PH_DATALEN:
                    begin
                        rem = acc;
                        ph  = (acc == '0) ? PH_HALT : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        emit          = 1'b1;
                        out_byte_next = acc[lsbsd_pkg::BYTE_W-1:0];
                        kind_next     = lsbsd_pkg::KIND_DATA;
                        last_next     = (rem == lsbsd_pkg::FIELD_W'(1));
                        rem           = rem - lsbsd_pkg::FIELD_W'(1);
                        if (rem == '0)
                        begin
                            ph = PH_HALT;
                        end
                    end
                    default:
                    begin
                        ph = PH_HALT;
                    end
                endcase
                acc = '0;
            end
        end

        phase_next    = ph;
        skip_cnt_next = skc;
        bit_cnt_next  = bc;
        acc_next      = acc;
        remain_next   = rem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SKIP;
            skip_cnt_reg <= '0;
            bit_cnt_reg  <= '0;
            acc_reg      <= '0;
            remain_reg   <= '0;
        end
        else if (s1_valid_reg && advance)
        begin
            phase_reg    <= phase_next;
            skip_cnt_reg <= skip_cnt_next;
            bit_cnt_reg  <= bit_cnt_next;
            acc_reg      <= acc_next;
            remain_reg   <= remain_next;
        end
    end

    //------------------------------------------------------------------
    // Result register.
    //------------------------------------------------------------------
    always_comb
    begin
        if (advance)
        begin
            out_valid_next = s1_valid_reg && emit;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg && emit)
        begin
            out_byte_reg <= out_byte_next;
            kind_reg     <= kind_next;
            last_reg     <= last_next;
        end
    end

    assign result_ch.valid    = out_valid_reg;
    assign result_ch.out_byte = out_byte_reg;
    assign result_ch.kind     = kind_reg;
    assign result_ch.last     = last_reg;

    //------------------------------------------------------------------
    // Assertions.
    //------------------------------------------------------------------
    // An error word carries a zero byte and no last flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == lsbsd_pkg::KIND_ERROR) |-> (out_byte_reg == '0 && !last_reg))
        else $error("error word with nonzero byte or last flag");

    // A halted decoder fed a byte without start produces no word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance && !s1_start_reg && phase_reg == PH_HALT) |=> !out_valid_reg)
        else $error("word produced while halted");

    // No hidden bits are gathered while the header is being skipped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP) |-> (bit_cnt_reg == '0 && acc_reg == '0))
        else $error("bits gathered during header skip");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the LSB steganography stream decoder unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsbsd_pkg::*;

    // Decoder progress through one carrier file, as tracked by the predictor.
    typedef enum logic [PHASE_W-1:0] {
        ST_HEADER,
        ST_MAGIC,
        ST_EXT_LEN,
        ST_EXT_BYTES,
        ST_DATA_LEN,
        ST_DATA_BYTES,
        ST_HALTED
    } decode_phase_t;

    // One decoded result word as it should appear on the result channel.
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [KIND_W-1:0] kind;
        logic              last_flag;
    } decoded_word_t;

    // The scoreboard carries its own copy of the decoder registers and state.
    // note_byte advances that state by one accepted carrier byte and queues any
    // word the byte should produce; check_word compares a received word with
    // the oldest queued one.
    class stego_scoreboard;
        logic [MAGIC_W-1:0] magic_expected;
        logic [SKIP_W-1:0]  skip_len;
        decode_phase_t      phase;
        logic [SKIP_W-1:0]  skip_cnt;
        logic [BITC_W-1:0]  bit_cnt;
        logic [FIELD_W-1:0] gathered;
        logic [FIELD_W-1:0] bytes_left;
        decoded_word_t      pending[$];
        int unsigned        mismatches;
        int unsigned        ext_words;
        int unsigned        data_words;
        int unsigned        error_words;

        function new();
            magic_expected = MAGIC_WORD_RST;
            skip_len       = HEADER_SKIP_RST;
            mismatches     = 0;
            ext_words      = 0;
            data_words     = 0;
            error_words    = 0;
            restart();
        endfunction

        function void restart();
            phase      = ST_HEADER;
            skip_cnt   = '0;
            bit_cnt    = '0;
            gathered   = '0;
            bytes_left = '0;
        endfunction

        function void set_register(logic idx, logic [APB_DW-1:0] value);
            if (idx == REG_MAGIC_WORD)
                magic_expected = value[MAGIC_W-1:0];
            else
                skip_len = value[SKIP_W-1:0];
        endfunction

        function void queue_word(logic [BYTE_W-1:0] value, logic [KIND_W-1:0] kind,
                                 logic last_flag);
            decoded_word_t w;
            w.value     = value;
            w.kind      = kind;
            w.last_flag = last_flag;
            pending.push_back(w);
        endfunction

        // Returns 1 when the byte did any work, 0 when a halted decoder ignored it.
        function bit note_byte(logic [BYTE_W-1:0] carrier, logic start);
            logic [BITC_W-1:0]  width;
            logic [FIELD_W-1:0] value;
            if (start)
                restart();
            if (phase == ST_HALTED)
                return 1'b0;
            if (phase == ST_HEADER)
            begin
                if (skip_cnt < skip_len)
                begin
                    skip_cnt++;
                    return 1'b1;
                end
                phase    = ST_MAGIC;
                bit_cnt  = '0;
                gathered = '0;
            end
            case (phase)
                ST_MAGIC:                width = MAGIC_BITS;
                ST_EXT_LEN, ST_DATA_LEN: width = LENGTH_BITS;
                default:                 width = BYTE_BITS;
            endcase
            // Bits arrive least significant first; the counter wraps at 32,
            // which is how a 32-bit length field completes.
            gathered[bit_cnt] = carrier[0];
            bit_cnt++;
            if (bit_cnt != width)
                return 1'b1;
            value    = gathered;
            bit_cnt  = '0;
            gathered = '0;
            case (phase)
                ST_MAGIC:
                begin
                    if (value[MAGIC_W-1:0] != magic_expected)
                    begin
                        phase = ST_HALTED;
                        queue_word('0, KIND_ERROR, 1'b0);
                        error_words++;
                    end
                    else
                        phase = ST_EXT_LEN;
                end
                ST_EXT_LEN:
                begin
                    bytes_left = value;
                    phase = (value == '0) ? ST_DATA_LEN : ST_EXT_BYTES;
                end
                ST_EXT_BYTES:
                begin
                    queue_word(value[BYTE_W-1:0], KIND_EXT, bytes_left == 32'd1);
                    ext_words++;
                    bytes_left--;
                    if (bytes_left == '0)
                        phase = ST_DATA_LEN;
                end
                ST_DATA_LEN:
                begin
                    bytes_left = value;
                    phase = (value == '0) ? ST_HALTED : ST_DATA_BYTES;
                end
                ST_DATA_BYTES:
                begin
                    queue_word(value[BYTE_W-1:0], KIND_DATA, bytes_left == 32'd1);
                    data_words++;
                    bytes_left--;
                    if (bytes_left == '0)
                        phase = ST_HALTED;
                end
                default:
                    phase = ST_HALTED;
            endcase
            return 1'b1;
        endfunction

        task report_mismatch(string what);
            $display("ERROR at %0t ns: %s", $realtime, what);
            mismatches++;
        endtask

        task check_word(logic [BYTE_W-1:0] value, logic [KIND_W-1:0] kind, logic last_flag);
            decoded_word_t w;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word %h kind %0d last %0b",
                                          value, kind, last_flag));
                return;
            end
            w = pending.pop_front();
            if (value !== w.value)
                report_mismatch($sformatf("out_byte %h, expected %h", value, w.value));
            if (kind !== w.kind)
                report_mismatch($sformatf("kind %0d, expected %0d", kind, w.kind));
            if (last_flag !== w.last_flag)
                report_mismatch($sformatf("last %0b, expected %0b", last_flag, w.last_flag));
        endtask

        task flush_missing();
            decoded_word_t w;
            while (pending.size() != 0)
            begin
                w = pending.pop_front();
                report_mismatch($sformatf("word %h kind %0d last %0b never arrived",
                                          w.value, w.kind, w.last_flag));
            end
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    lsbsd_in_if  stego_ch();
    lsbsd_out_if result_ch();

    lsb_stego_stream_decoder_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .stego_ch  (stego_ch),
        .result_ch (result_ch)
    );

    stego_scoreboard sb;

    // Sender burst bookkeeping and run statistics.
    int unsigned burst_left = 0;
    int unsigned live_bytes = 0;
    int unsigned total_bytes = 0;
    int unsigned settings_used = 1;
    // Set by the stimulus to ask the receiver for one long hold-off.
    bit          long_hold_req = 1'b0;
    // Hidden bit stream of the file being built.
    bit          file_bits[$];

    always #2 clk = ~clk;

    // The run is bounded; anything still going by then has hung.
    initial
    begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Offers one carrier byte and waits for it to be taken. The sender works
    // in bursts; when a burst runs out, valid drops for a random gap (or not
    // at all, so that back-to-back stretches occur too).
    task automatic send_word(input logic [BYTE_W-1:0] carrier, input logic start);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                stego_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        stego_ch.valid      <= 1'b1;
        stego_ch.stego_byte <= carrier;
        stego_ch.start_req  <= start;
        @(posedge clk);
        while (!stego_ch.ready)
            @(posedge clk);
        total_bytes++;
        if (sb.note_byte(carrier, start))
            live_bytes++;
    endtask

    // Writes one register over APB, then reads it back and checks the value.
    task automatic write_register(input logic idx, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_register(idx, value);
        if (readback !== ((idx == REG_MAGIC_WORD) ? {16'h0, sb.magic_expected}
                                                  : {24'h0, sb.skip_len}))
            sb.report_mismatch($sformatf("register %0d reads %h after writing %h",
                                         idx, readback, value));
    endtask

    // Stops offering bytes and lets every expected word come out. A byte that
    // yields no word may still sit in the pipeline, so the task waits on after
    // the last word before the decoder counts as idle.
    task automatic wait_idle();
        int unsigned waited;
        waited = 0;
        stego_ch.valid <= 1'b0;
        while (sb.pending.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        sb.flush_missing();
        repeat (4) @(posedge clk);
    endtask

    function automatic void push_field(input logic [FIELD_W-1:0] value, input int n);
        for (int i = 0; i < n; i++)
            file_bits.push_back(value[i]);
    endfunction

    // Payload bytes lean toward the all-zero and all-one extremes.
    function automatic logic [BYTE_W-1:0] hidden_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Sends one carrier file: the header bytes, then the hidden stream of
    // magic, extension length, extension bytes, data length and data bytes,
    // then a few trailing bytes. Long runs are capped, so a huge length is
    // left unfinished. cut_bits >= 0 truncates the hidden stream there.
    task automatic send_file(input bit with_start, input logic [MAGIC_W-1:0] magic_sent,
                             input logic [FIELD_W-1:0] ext_len,
                             input logic [FIELD_W-1:0] data_len, input int cut_bits);
        int unsigned n_ext;
        int unsigned n_data;
        int unsigned total;
        file_bits.delete();
        push_field({16'h0, magic_sent}, MAGIC_W);
        push_field(ext_len, FIELD_W);
        n_ext = (ext_len > 32'd6) ? 6 : ext_len;
        for (int i = 0; i < int'(n_ext); i++)
            push_field({24'h0, hidden_byte()}, BYTE_W);
        // Only a finished extension run reaches the data length field.
        if (n_ext == ext_len)
        begin
            push_field(data_len, FIELD_W);
            n_data = (data_len > 32'd40) ? 40 : data_len;
            for (int i = 0; i < int'(n_data); i++)
                push_field({24'h0, hidden_byte()}, BYTE_W);
        end
        total = file_bits.size();
        if (cut_bits >= 0 && cut_bits < int'(total))
            total = cut_bits;
        for (int i = 0; i < int'(sb.skip_len); i++)
            send_word(8'($urandom_range(0, 255)), with_start && i == 0);
        for (int i = 0; i < int'(total); i++)
            send_word({7'($urandom_range(0, 127)), file_bits[i]},
                      with_start && sb.skip_len == '0 && i == 0);
        repeat ($urandom_range(0, 3))
            send_word(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Receiver: checks every accepted word, and drives ready from a pattern
    // picked at random for each stretch (always ready, random stalls, or a
    // fixed duty cycle). On request it holds off for a long stretch so the
    // decoder fills up and pushes back on its input.
    initial
    begin : result_sink
        int unsigned hold_left;
        int unsigned mode_left;
        int unsigned mode;
        int unsigned tick;
        hold_left = 0;
        mode_left = 0;
        mode      = 0;
        tick      = 0;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                sb.check_word(result_ch.out_byte, result_ch.kind, result_ch.last);
            tick++;
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = 300;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: result_ch.ready <= ((tick % 7) >= 3);
                endcase
            end
        end
    end

    // Main stimulus.
    initial
    begin : stimulus
        int unsigned round;
        int unsigned choice;
        sb = new();
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        stego_ch.valid      <= 1'b0;
        stego_ch.stego_byte <= '0;
        stego_ch.start_req  <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight out of reset the decoder must already be in a file: no
        // start flag, default header length and magic, an empty extension
        // and a single data byte.
        send_file(1'b0, MAGIC_WORD_RST, 32'd0, 32'd1, -1);
        wait_idle();

        // With no header the very first byte of a file carries a hidden bit.
        write_register(REG_HEADER_SKIP, 32'd0);
        // Two extension bytes and an empty data run, then a file without a
        // start flag that the halted decoder must ignore.
        send_file(1'b1, MAGIC_WORD_RST, 32'd2, 32'd0, -1);
        send_file(1'b0, MAGIC_WORD_RST, 32'd1, 32'd1, -1);
        // Magic mismatches in the second and in the first character; the
        // bytes that follow an error are ignored.
        send_file(1'b1, MAGIC_WORD_RST ^ 16'h0100, 32'd1, 32'd1, 20);
        send_file(1'b1, MAGIC_WORD_RST ^ 16'h0001, 32'd1, 32'd1, 16);
        // Full file with single-byte and multi-byte runs.
        send_file(1'b1, MAGIC_WORD_RST, 32'd1, 32'd3, -1);
        // A new start that arrives while the extension length is three quarters read.
        send_file(1'b1, MAGIC_WORD_RST, 32'd1, 32'd2, 40);
        // The largest data length, then a file without a start flag that
        // simply continues the unfinished data run.
        send_file(1'b1, MAGIC_WORD_RST, 32'd0, 32'hFFFF_FFFF, -1);
        send_file(1'b0, MAGIC_WORD_RST, 32'd0, 32'd1, -1);
        wait_idle();

        // Register extremes: all-ones magic with the longest header, then an
        // all-zero magic with a one-byte header.
        write_register(REG_MAGIC_WORD, 32'hFFFF);
        write_register(REG_HEADER_SKIP, 32'd255);
        send_file(1'b1, 16'hFFFF, 32'd1, 32'd1, -1);
        wait_idle();
        write_register(REG_MAGIC_WORD, 32'h0000);
        write_register(REG_HEADER_SKIP, 32'd1);
        send_file(1'b1, 16'h0000, 32'd0, 32'd2, -1);
        settings_used += 3;

        // Random part: rounds of a fresh register setting followed by a few
        // files. Most files are well formed with random content and lengths;
        // the rest carry a bad magic, are cut short by a new start, announce
        // a huge length, or lack their start flag.
        live_bytes = 0;
        round = 0;
        while (live_bytes < 400)
        begin
            wait_idle();
            write_register(REG_MAGIC_WORD, 32'($urandom_range(0, 65535)));
            write_register(REG_HEADER_SKIP, ($urandom_range(0, 4) == 0)
                                            ? 32'($urandom_range(9, 60))
                                            : 32'($urandom_range(0, 8)));
            settings_used++;
            for (int f = 0; f < 5; f++)
            begin
                choice = $urandom_range(0, 19);
                if (round == 0 && f == 0)
                begin
                    // Long data run while the receiver holds off.
                    long_hold_req = 1'b1;
                    send_file(1'b1, sb.magic_expected, 32'd0, 32'd24, -1);
                end
                else if (choice < 14)
                    send_file(1'b1, sb.magic_expected,
                              32'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5)),
                              32'(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6)), -1);
                else if (choice < 16)
                    send_file(1'b1, sb.magic_expected ^ 16'(1 << $urandom_range(0, 15)),
                              32'd1, 32'd1, 16 + $urandom_range(0, 8));
                else if (choice < 18)
                    send_file(1'b1, sb.magic_expected, 32'($urandom_range(0, 3)),
                              32'($urandom_range(1, 4)), $urandom_range(0, 120));
                else if (choice == 18)
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_file(1'b1, sb.magic_expected, 32'($urandom()), 32'd1, -1);
                    else
                        send_file(1'b1, sb.magic_expected, 32'd0, 32'($urandom()), -1);
                end
                else
                    send_file(1'b0, sb.magic_expected, 32'd1, 32'd1, -1);
            end
            round++;
        end

        wait_idle();
        repeat (8) @(posedge clk);

        $display("Run covered %0d carrier bytes under %0d register settings.",
                 total_bytes, settings_used);
        $display("Checked %0d extension, %0d data and %0d error words.",
                 sb.ext_words, sb.data_words, sb.error_words);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
